// ===== sv/bsa_pkg.sv =====
// Shared types and codes for the bounded sorted array engine.
package bsa_pkg;

   // Width of position and limit fields carried to the cells (covers depth 1024)
   localparam int POS_W = 11;

   // Request operation codes
   localparam logic [3:0] OP_APPEND   = 4'd0;
   localparam logic [3:0] OP_SEARCH   = 4'd1;
   localparam logic [3:0] OP_REMOVE   = 4'd2;
   localparam logic [3:0] OP_INSERT   = 4'd3;
   localparam logic [3:0] OP_SORT     = 4'd4;
   localparam logic [3:0] OP_REVERSE  = 4'd5;
   localparam logic [3:0] OP_READ_AT  = 4'd6;
   localparam logic [3:0] OP_EXTREMES = 4'd7;
   localparam logic [3:0] OP_CLEAR    = 4'd8;

   // Response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_BEYOND    = 2'd3;

   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

   // Command broadcast to every cell of the row
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_ROT,
      CELL_DEL,
      CELL_INS,
      CELL_SORT
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [POS_W-1:0]   pos;
      logic [POS_W-1:0]   lim;
      logic               phase;
      logic signed [31:0] value;
   } cell_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_SHIFT,
      ST_SORTING,
      ST_REVERSING,
      ST_DONE
   } state_type;

endpackage

// ===== sv/bounded_sorted_array_engine.sv =====
// Top level of the bounded sorted array engine: controller and row of cells.
//
// Usage: a request (req_op, req_value, req_index) is taken when req_valid is
// high and req_stall low; one response (rsp_status, rsp_position,
// rsp_first_word, rsp_second_word, rsp_element_count) follows on the rsp_
// channel, taken when rsp_valid is high and rsp_stall low. One request is
// worked on at a time; req_stall is high while it is in progress.
// Work per request, with n the element count:
//   append, clear, unused codes, and cases settled at once: no scan
//   search, read_at, extremes: the first n cells rotate, one element
//   passing the head cell per cycle
//   remove, insert_sorted: a scan, then one shift of the row
//   sort: n odd-even exchange passes across the row
//   reverse: n - 1 prefix rotations
// The next request is taken at the earliest in the cycle after a response loads.
// The response sits in an output register; the next request is taken while
// it waits. If rsp_stall holds a response, a finished request waits until
// the register frees. csr_wr_en writes the capacity; the user must write it
// only at idle time, which the block does not enforce. Reset (synchronous,
// active high) empties the array, sets the capacity to 32 and drops any pending response; stored words are not cleared.
module bounded_sorted_array_engine #(
   parameter int DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [5:0]         csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_op,
   input  logic signed [31:0] req_value,
   input  logic [4:0]         req_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_position,
   output logic signed [31:0] rsp_first_word,
   output logic signed [31:0] rsp_second_word,
   output logic [5:0]         rsp_element_count
);
   import bsa_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   // Row of cells
   cell_cmd_type       cmd;
   logic signed [31:0] words [DEPTH];
   logic               swaps [DEPTH];
   logic signed [31:0] head;

   assign head = words[0];

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [31:0] lw, rw;
      logic               si;
      if (g == 0) begin : g_first
         assign lw = '0;
         assign si = 1'b0;
      end else begin : g_mid
         assign lw = words[g-1];
         assign si = swaps[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign rw = '0;
      end else begin : g_inner
         assign rw = words[g+1];
      end
      bsa_cell #(.IDX(g)) u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .head     (head),
         .left     (lw),
         .right    (rw),
         .swap_in  (si),
         .swap_out (swaps[g]),
         .word     (words[g])
      );
   end

   // Control and result registers
   state_type          state_ff, state_in;
   logic [5:0]         cap_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      step_ff, step_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic               hit_ff, hit_in;
   logic [1:0]         status_ff, status_in;
   logic signed [31:0] w1_ff, w1_in, w2_ff, w2_in;
   logic [3:0]         op_ff;
   logic signed [31:0] value_ff;
   logic [4:0]         idx_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff;
   logic [CW-1:0]      rsp_pos_ff, rsp_count_ff;
   logic signed [31:0] rsp_w1_ff, rsp_w2_ff;
   logic               load_rsp;
   logic               full;
   logic               last;

   assign full = (32'(count_ff) >= 32'(cap_ff)) || (32'(count_ff) >= DEPTH);
   assign last = (step_ff == count_ff - CW'(1));
   assign req_stall = (state_ff != ST_IDLE);

   // Next state, cell command and result updates
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      pos_in    = pos_ff;
      hit_in    = hit_ff;
      status_in = status_ff;
      w1_in     = w1_ff;
      w2_in     = w2_ff;
      load_rsp  = 1'b0;
      cmd       = '{op: CELL_HOLD, pos: '0, lim: POS_W'(count_ff), phase: 1'b0,
                    value: value_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in  = ST_DISPATCH;
               pos_in    = '0;
               hit_in    = 1'b0;
               status_in = ST_OK;
               w1_in     = '0;
               w2_in     = '0;
               step_in   = '0;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_DONE;
            unique case (op_ff)
               OP_APPEND: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.op   = CELL_WRITE;
                     cmd.pos  = POS_W'(count_ff);
                     pos_in   = count_ff;
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_SEARCH, OP_REMOVE: begin
                  if (count_ff == '0) status_in = ST_NOT_FOUND;
                  else state_in = ST_SCAN;
               end
               OP_INSERT: begin
                  if (full) status_in = ST_FULL;
                  else if (count_ff == '0) state_in = ST_SHIFT;
                  else state_in = ST_SCAN;
               end
               OP_SORT: begin
                  if (count_ff > CW'(1)) state_in = ST_SORTING;
               end
               OP_REVERSE: begin
                  if (count_ff > CW'(1)) begin
                     step_in  = count_ff - CW'(1);
                     state_in = ST_REVERSING;
                  end
               end
               OP_READ_AT: begin
                  if (32'(idx_ff) >= 32'(count_ff)) status_in = ST_BEYOND;
                  else state_in = ST_SCAN;
               end
               OP_EXTREMES: begin
                  if (count_ff == '0) begin
                     w1_in = WORD_MIN;
                     w2_in = WORD_MAX;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               OP_CLEAR: count_in = '0;
               default: state_in = ST_DONE;
            endcase
         end
         ST_SCAN: begin
            // Rotate the occupied prefix; element step_ff is at the head
            cmd.op  = CELL_ROT;
            step_in = step_ff + CW'(1);
            unique case (op_ff)
               OP_SEARCH, OP_REMOVE: begin
                  if (!hit_ff && head == value_ff) begin
                     hit_in = 1'b1;
                     pos_in = step_ff;
                  end
               end
               OP_INSERT: begin
                  if (!hit_ff && !(value_ff > head)) begin
                     hit_in = 1'b1;
                     pos_in = step_ff;
                  end
               end
               OP_READ_AT: begin
                  if (32'(step_ff) == 32'(idx_ff)) w1_in = head;
               end
               OP_EXTREMES: begin
                  if (step_ff == '0) begin
                     w1_in = head;
                     w2_in = head;
                  end else begin
                     if (head > w1_ff) w1_in = head;
                     if (head < w2_ff) w2_in = head;
                  end
               end
               default: ;
            endcase
            if (last) begin
               state_in = ST_DONE;
               unique case (op_ff)
                  OP_SEARCH: begin
                     if (!hit_in) status_in = ST_NOT_FOUND;
                  end
                  OP_REMOVE: begin
                     if (hit_in) state_in = ST_SHIFT;
                     else status_in = ST_NOT_FOUND;
                  end
                  OP_INSERT: begin
                     if (!hit_in) pos_in = count_ff;
                     state_in = ST_SHIFT;
                  end
                  default: ;
               endcase
            end
         end
         ST_SHIFT: begin
            // Close or open the gap at the found position
            cmd.pos  = POS_W'(pos_ff);
            state_in = ST_DONE;
            if (op_ff == OP_REMOVE) begin
               cmd.op   = CELL_DEL;
               count_in = count_ff - CW'(1);
            end else begin
               cmd.op   = CELL_INS;
               count_in = count_ff + CW'(1);
            end
         end
         ST_SORTING: begin
            // One odd-even exchange pass per cycle
            cmd.op    = CELL_SORT;
            cmd.phase = step_ff[0];
            step_in   = step_ff + CW'(1);
            if (last) state_in = ST_DONE;
         end
         ST_REVERSING: begin
            // Rotate prefix of length step+1 left by one
            cmd.op  = CELL_ROT;
            cmd.lim = POS_W'(step_ff) + POS_W'(1);
            step_in = step_ff - CW'(1);
            if (step_ff == CW'(1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Response register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= 6'd32;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) cap_ff <= csr_wr_data;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      pos_ff    <= pos_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      w1_ff     <= w1_in;
      w2_ff     <= w2_in;
      if (state_ff == ST_IDLE && req_valid) begin
         op_ff    <= req_op;
         value_ff <= req_value;
         idx_ff   <= req_index;
      end
      if (load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_pos_ff    <= pos_ff;
         rsp_w1_ff     <= w1_ff;
         rsp_w2_ff     <= w2_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   // Drive response ports
   logic [31:0] pos_wide, count_wide;
   assign pos_wide   = 32'(rsp_pos_ff);
   assign count_wide = 32'(rsp_count_ff);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_position      = pos_wide[4:0];
   assign rsp_first_word    = rsp_w1_ff;
   assign rsp_second_word   = rsp_w2_ff;
   assign rsp_element_count = count_wide[5:0];

endmodule

// ===== sv/bsa_cell.sv =====
// One storage cell of the element row: holds a word and trades with its neighbours.
module bsa_cell #(
   parameter int IDX = 0
) (
   input  logic                  clock,
   input  bsa_pkg::cell_cmd_type cmd,
   input  logic signed [31:0]    head,
   input  logic signed [31:0]    left,
   input  logic signed [31:0]    right,
   input  logic                  swap_in,
   output logic                  swap_out,
   output logic signed [31:0]    word
);
   import bsa_pkg::*;

   localparam logic [POS_W-1:0] MY   = POS_W'(IDX);
   localparam logic [POS_W-1:0] NEXT = POS_W'(IDX + 1);
   localparam logic             PAR  = 1'(IDX % 2);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   // Lower cell of an active pair decides the compare-exchange
   assign swap_out = (cmd.op == CELL_SORT) && (cmd.phase == PAR) &&
                     (NEXT < cmd.lim) && (data_ff > right);

   // Select next word from command
   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         CELL_HOLD: data_in = data_ff;
         CELL_WRITE: begin
            if (cmd.pos == MY) data_in = cmd.value;
         end
         CELL_ROT: begin
            if (NEXT < cmd.lim) data_in = right;
            else if (NEXT == cmd.lim) data_in = head;
         end
         CELL_DEL: begin
            if (MY >= cmd.pos) data_in = right;
         end
         CELL_INS: begin
            if (MY > cmd.pos) data_in = left;
            else if (MY == cmd.pos) data_in = cmd.value;
         end
         CELL_SORT: begin
            if (swap_out) data_in = right;
            else if (swap_in) data_in = left;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign word = data_ff;

endmodule

// ===== tb/tb_bounded_sorted_array_engine.sv =====
// Self-checking testbench for the bounded sorted array engine.
`timescale 1ns / 1ps

module tb_bounded_sorted_array_engine;
   import bsa_pkg::*;

   localparam int CAP_MAX = 32;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [1:0]         status;
      logic [4:0]         position;
      logic signed [31:0] first_word;
      logic signed [31:0] second_word;
      logic [5:0]         element_count;
   } outcome_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [5:0]         csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [3:0]         req_op = '0;
   logic signed [31:0] req_value = '0;
   logic [4:0]         req_index = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_position;
   logic signed [31:0] rsp_first_word;
   logic signed [31:0] rsp_second_word;
   logic [5:0]         rsp_element_count;

   // Predictor state
   logic signed [31:0] shadow_words [CAP_MAX];
   int                 shadow_count;
   int                 shadow_capacity;
   outcome_type        expected_outcomes [$];

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_off = 1'b0;
   int  failures = 0;
   int  requests_sent = 0;
   int  responses_seen = 0;
   longint cycle_count = 0;

   bounded_sorted_array_engine dut (.*);

   always #6 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // Drive the receiver stall; a hold-off forces it high
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
      end
   end

   // Compute the expected outcome of one request and update the shadow array
   function automatic outcome_type predict_array_op(logic [3:0] op, logic signed [31:0] v,
                                                    logic [4:0] idx);
      outcome_type o;
      int          i, j, p;
      logic signed [31:0] t;
      o = '0;
      case (op)
         OP_APPEND: begin
            if (shadow_count >= shadow_capacity) begin
               o.status = ST_FULL;
            end else begin
               shadow_words[shadow_count] = v;
               o.position = 5'(shadow_count);
               shadow_count++;
            end
         end
         OP_SEARCH, OP_REMOVE: begin
            p = -1;
            for (i = 0; i < shadow_count; i++)
               if (p < 0 && shadow_words[i] == v) p = i;
            if (p < 0) begin
               o.status = ST_NOT_FOUND;
            end else begin
               o.position = 5'(p);
               if (op == OP_REMOVE) begin
                  for (i = p; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
                  shadow_count--;
               end
            end
         end
         OP_INSERT: begin
            if (shadow_count >= shadow_capacity) begin
               o.status = ST_FULL;
            end else begin
               p = 0;
               while (p < shadow_count && v > shadow_words[p]) p++;
               for (i = shadow_count; i > p; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[p] = v;
               o.position = 5'(p);
               shadow_count++;
            end
         end
         OP_SORT: begin
            for (i = 0; i + 1 < shadow_count; i++)
               for (j = 0; j + 1 < shadow_count - i; j++)
                  if (shadow_words[j] > shadow_words[j+1]) begin
                     t = shadow_words[j];
                     shadow_words[j] = shadow_words[j+1];
                     shadow_words[j+1] = t;
                  end
         end
         OP_REVERSE: begin
            i = 0;
            j = shadow_count - 1;
            while (i < j) begin
               t = shadow_words[i];
               shadow_words[i] = shadow_words[j];
               shadow_words[j] = t;
               i++;
               j--;
            end
         end
         OP_READ_AT: begin
            if (idx >= shadow_count) o.status = ST_BEYOND;
            else o.first_word = shadow_words[idx];
         end
         OP_EXTREMES: begin
            if (shadow_count == 0) begin
               o.first_word = WORD_MIN;
               o.second_word = WORD_MAX;
            end else begin
               o.first_word = shadow_words[0];
               o.second_word = shadow_words[0];
               for (i = 1; i < shadow_count; i++) begin
                  if (shadow_words[i] > o.first_word) o.first_word = shadow_words[i];
                  if (shadow_words[i] < o.second_word) o.second_word = shadow_words[i];
               end
            end
         end
         OP_CLEAR: shadow_count = 0;
         default: ;
      endcase
      o.element_count = 6'(shadow_count);
      return o;
   endfunction

   // Check each accepted response against the oldest expectation
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (expected_outcomes.size() == 0) begin
            $error("Response with no request outstanding");
            failures++;
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_position);
               failures++;
            end
            if (rsp_first_word !== want.first_word) begin
               $error("first_word: expected %0d, got %0d", want.first_word, rsp_first_word);
               failures++;
            end
            if (rsp_second_word !== want.second_word) begin
               $error("second_word: expected %0d, got %0d", want.second_word,
                      rsp_second_word);
               failures++;
            end
            if (rsp_element_count !== want.element_count) begin
               $error("element_count: expected %0d, got %0d", want.element_count,
                      rsp_element_count);
               failures++;
            end
         end
      end
   end

   // Offer one request, hold it until taken, then record its expectation
   task automatic send_request(logic [3:0] op, logic signed [31:0] v, logic [4:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= v;
      req_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_outcomes.push_back(predict_array_op(op, v, idx));
      requests_sent++;
   endtask

   // Drop the request valid and wait for every outstanding response
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (CAP_MAX + 10) @(posedge clock);
   endtask

   task automatic write_capacity(logic [5:0] cap);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_capacity = (cap > CAP_MAX) ? CAP_MAX : cap;
   endtask

   // Values biased toward extremes and repeats so matches occur
   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(5))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return $urandom;
         default: return $signed($urandom_range(15)) - 8;
      endcase
   endfunction

   function automatic logic [3:0] pick_op();
      int r;
      r = $urandom_range(99);
      if (r < 30) return OP_APPEND;
      if (r < 45) return OP_INSERT;
      if (r < 55) return OP_SEARCH;
      if (r < 65) return OP_REMOVE;
      if (r < 72) return OP_READ_AT;
      if (r < 78) return OP_EXTREMES;
      if (r < 83) return OP_SORT;
      if (r < 88) return OP_REVERSE;
      if (r < 92) return OP_CLEAR;
      return 4'($urandom_range(15));
   endfunction

   task automatic run_random(int n);
      for (int k = 0; k < n; k++)
         send_request(pick_op(), pick_word(), 5'($urandom_range(31)));
   endtask

   task automatic test_directed_ops();
      send_request(OP_EXTREMES, 0, 0);
      send_request(OP_READ_AT, 0, 0);
      send_request(OP_SEARCH, 5, 0);
      send_request(OP_REMOVE, 5, 0);
      send_request(OP_APPEND, WORD_MAX, 0);
      send_request(OP_APPEND, WORD_MIN, 0);
      send_request(OP_APPEND, 3, 0);
      send_request(OP_INSERT, 3, 0);
      send_request(OP_INSERT, -1, 0);
      send_request(OP_SEARCH, 3, 0);
      send_request(OP_EXTREMES, 0, 0);
      send_request(OP_SORT, 0, 0);
      send_request(OP_REVERSE, 0, 0);
      send_request(OP_READ_AT, 0, 5'd4);
      send_request(OP_READ_AT, 0, 5'd31);
      send_request(OP_REMOVE, 3, 0);
      send_request(4'd9, 0, 0);
      send_request(4'd15, -1, 5'd31);
      send_request(OP_CLEAR, 0, 0);
   endtask

   task automatic test_capacity_limits();
      write_capacity(6'd0);
      send_request(OP_APPEND, 1, 0);
      send_request(OP_INSERT, 1, 0);
      write_capacity(6'd63);
      for (int k = 0; k < CAP_MAX + 1; k++) send_request(OP_APPEND, pick_word(), 0);
      send_request(OP_INSERT, 0, 0);
      send_request(OP_SORT, 0, 0);
      send_request(OP_READ_AT, 0, 5'd31);
      write_capacity(6'd4);
      send_request(OP_APPEND, 2, 0);
      send_request(OP_CLEAR, 0, 0);
      write_capacity(6'd1);
      run_random(40);
      write_capacity(6'd32);
   endtask

   task automatic test_random_phases();
      int pct [4][2] = '{'{0, 0}, '{54, 0}, '{0, 54}, '{8, 8}};
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = pct[ph][0];
         stall_pct = pct[ph][1];
         write_capacity(6'($urandom_range(2, 32)));
         run_random(220);
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   // Long receiver hold-off while requests keep coming, then a full pause
   task automatic test_backpressure();
      hold_off <= 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_off <= 1'b0;
         end
         run_random(8);
      join
      drain_responses();
      run_random(60);
   endtask

   initial begin
      for (int i = 0; i < CAP_MAX; i++) shadow_words[i] = '0;
      shadow_count = 0;
      shadow_capacity = CAP_MAX;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_ops();
      test_capacity_limits();
      test_random_phases();
      test_backpressure();
      drain_responses();
      $display("Sent %0d requests, checked %0d responses across capacities 0 to 63",
               requests_sent, responses_seen);
      if (failures == 0 && expected_outcomes.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
